### hdl/rvalu_pkg.sv
// Shared types and encodings for the RV64I integer ALU execute unit.
// No dependencies; imported by the ALU, the top level, the checker and the testbench.
package rvalu_pkg;

	localparam int XLEN      = 64;
	localparam int REG_COUNT = 32;
	localparam int REG_AW    = 5;

	// major opcodes
	localparam logic [6:0] OPC_IMM   = 7'h13;
	localparam logic [6:0] OPC_IMM32 = 7'h1b;
	localparam logic [6:0] OPC_REG   = 7'h33;
	localparam logic [6:0] OPC_REG32 = 7'h3b;

	// funct3 codes
	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	// funct7 and shift-immediate upper bits
	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_ALT  = 7'h20;
	localparam logic [5:0] TOP6_SRL = 6'h00;
	localparam logic [5:0] TOP6_SRA = 6'h10;

	typedef struct packed {
		logic [XLEN-1:0] value;
		logic            illegal;
	} alu_res_t;

	function automatic logic [XLEN-1:0] sext32(input logic [31:0] x);
		sext32 = {{(XLEN-32){x[31]}}, x};
	endfunction

endpackage

### hdl/rvalu_ram.sv
// Generic simple memory: one write port, two registered read ports.
// No dependencies.
module rvalu_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// read returns the old word on a same-edge write
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

### hdl/rvalu_alu.sv
// Decode and execute of OP-IMM, OP-IMM-32, OP and OP-32 instructions.
// Depends on rvalu_pkg.
module rvalu_alu
	import rvalu_pkg::*;
(
	input  logic [31:0]     instruction,
	input  logic [XLEN-1:0] op_a,
	input  logic [XLEN-1:0] op_b,
	output alu_res_t        res
);

	logic [6:0]      opc;
	logic [2:0]      f3;
	logic [6:0]      f7;
	logic [5:0]      top6;
	logic [XLEN-1:0] imm;
	logic [5:0]      sh_imm;
	logic [5:0]      sh_reg;
	logic [31:0]     lo;
	logic [XLEN-1:0] value;
	logic            ok;

	assign opc    = instruction[6:0];
	assign f3     = instruction[14:12];
	assign f7     = instruction[31:25];
	assign top6   = instruction[31:26];
	assign imm    = {{(XLEN-12){instruction[31]}}, instruction[31:20]};
	assign sh_imm = instruction[25:20];
	assign sh_reg = op_b[5:0];
	assign lo     = op_a[31:0];

	always_comb begin
		value = '0;
		ok    = 1'b0;
		case (opc)
			OPC_IMM: begin
				ok = 1'b1;
				case (f3)
					F3_ADD:  value = op_a + imm;
					F3_SLT:  value = {{(XLEN-1){1'b0}}, $signed(op_a) < $signed(imm)};
					F3_SLTU: value = {{(XLEN-1){1'b0}}, op_a < imm};
					F3_XOR:  value = op_a ^ imm;
					F3_OR:   value = op_a | imm;
					F3_AND:  value = op_a & imm;
					F3_SLL: begin
						ok = (top6 == TOP6_SRL);
						if (ok) value = op_a << sh_imm;
					end
					default: begin
						if (top6 == TOP6_SRL) begin
							value = op_a >> sh_imm;
						end else if (top6 == TOP6_SRA) begin
							value = $unsigned($signed(op_a) >>> sh_imm);
						end else begin
							ok = 1'b0;
						end
					end
				endcase
			end
			OPC_IMM32: begin
				case (f3)
					F3_ADD: begin
						ok    = 1'b1;
						value = sext32(lo + imm[31:0]);
					end
					F3_SLL: begin
						ok = (f7 == F7_BASE);
						if (ok) value = sext32(lo << sh_imm[4:0]);
					end
					F3_SR: begin
						if (f7 == F7_BASE) begin
							ok    = 1'b1;
							value = sext32(lo >> sh_imm[4:0]);
						end else if (f7 == F7_ALT) begin
							ok    = 1'b1;
							value = sext32($unsigned($signed(lo) >>> sh_imm[4:0]));
						end
					end
					default: ok = 1'b0;
				endcase
			end
			OPC_REG: begin
				if (f7 == F7_ALT) begin
					if (f3 == F3_ADD) begin
						ok    = 1'b1;
						value = op_a - op_b;
					end else if (f3 == F3_SR) begin
						ok    = 1'b1;
						value = $unsigned($signed(op_a) >>> sh_reg);
					end
				end else if (f7 == F7_BASE) begin
					ok = 1'b1;
					case (f3)
						F3_ADD:  value = op_a + op_b;
						F3_SLL:  value = op_a << sh_reg;
						F3_SLT:  value = {{(XLEN-1){1'b0}}, $signed(op_a) < $signed(op_b)};
						F3_SLTU: value = {{(XLEN-1){1'b0}}, op_a < op_b};
						F3_XOR:  value = op_a ^ op_b;
						F3_SR:   value = op_a >> sh_reg;
						F3_OR:   value = op_a | op_b;
						default: value = op_a & op_b;
					endcase
				end
			end
			OPC_REG32: begin
				if (f7 == F7_ALT) begin
					if (f3 == F3_ADD) begin
						ok    = 1'b1;
						value = sext32(lo - op_b[31:0]);
					end else if (f3 == F3_SR) begin
						ok    = 1'b1;
						value = sext32($unsigned($signed(lo) >>> sh_reg[4:0]));
					end
				end else if (f7 == F7_BASE) begin
					if (f3 == F3_ADD) begin
						ok    = 1'b1;
						value = sext32(lo + op_b[31:0]);
					end else if (f3 == F3_SLL) begin
						ok    = 1'b1;
						value = sext32(lo << sh_reg[4:0]);
					end else if (f3 == F3_SR) begin
						ok    = 1'b1;
						value = sext32(lo >> sh_reg[4:0]);
					end
				end
			end
			default: ok = 1'b0;
		endcase
		res.value   = value;
		res.illegal = !ok;
	end

endmodule

### hdl/rv64i_integer_alu_execute_unit.sv
// RV64I integer ALU execute unit: register file, operand forwarding, result register.
// Depends on rvalu_pkg, rvalu_ram and rvalu_alu.
// Each accepted instruction passes stage 1, then the stage 2 result register, to the output.
// Throughput: one instruction per cycle while result beats are taken, set by the two-port
// register file with registered reads and a same-cycle bypass from the execute stage.
// Reset: control and per-register written flags clear at once; unwritten registers read zero.
module rv64i_integer_alu_execute_unit
	import rvalu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// instruction beats
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] instruction
	// result beats
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // [4:0] dest_index, [68:5] dest_value, [71:69] zero
	output logic [1:0]  m_axis_tuser    // [0] write_done, [1] illegal
);

	// Stage 1 holds the instruction while the register file read completes and the ALU works;
	// stage 2 is the result register that faces the output channel.
	logic                 valid_s1;
	logic [31:0]          ins_s1;
	logic                 fwd_a_s1;
	logic                 fwd_b_s1;
	logic                 zero_a_s1;
	logic                 zero_b_s1;
	logic [XLEN-1:0]      fwd_val_s1;

	logic                 valid_s2;
	logic [REG_AW-1:0]    dest_index_s2;
	logic [XLEN-1:0]      dest_value_s2;
	logic                 write_done_s2;
	logic                 illegal_s2;

	// one flag per register: set once written, so unwritten entries read as zero
	logic [REG_COUNT-1:0] written_q;

	logic                 accept;
	logic                 advance;
	logic                 commit;
	logic [REG_AW-1:0]    rs1_in;
	logic [REG_AW-1:0]    rs2_in;
	logic [REG_AW-1:0]    rd_s1;
	logic [XLEN-1:0]      ram_a;
	logic [XLEN-1:0]      ram_b;
	logic [XLEN-1:0]      op_a;
	logic [XLEN-1:0]      op_b;
	alu_res_t             alu_res;

	assign rs1_in = s_axis_tdata[19:15];
	assign rs2_in = s_axis_tdata[24:20];
	assign rd_s1  = ins_s1[11:7];

	// Stage 1 moves on whenever the result register is empty or being drained.
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || !valid_s2 || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	// x0 is never written, so its flag stays clear and it always reads zero
	assign commit        = advance && !alu_res.illegal && (rd_s1 != '0);

	rvalu_ram #(
		.WIDTH (XLEN),
		.DEPTH (REG_COUNT)
	) u_regfile (
		.clk     (clk),
		.we      (commit),
		.waddr   (rd_s1),
		.wdata   (alu_res.value),
		.re      (accept),
		.raddr_a (rs1_in),
		.raddr_b (rs2_in),
		.rdata_a (ram_a),
		.rdata_b (ram_b)
	);

	// Bypass beats the never-written zero, which beats the stored word.
	always_comb begin
		if (fwd_a_s1) begin
			op_a = fwd_val_s1;
		end else if (zero_a_s1) begin
			op_a = '0;
		end else begin
			op_a = ram_a;
		end
		if (fwd_b_s1) begin
			op_b = fwd_val_s1;
		end else if (zero_b_s1) begin
			op_b = '0;
		end else begin
			op_b = ram_b;
		end
	end

	rvalu_alu u_alu (
		.instruction (ins_s1),
		.op_a        (op_a),
		.op_b        (op_b),
		.res         (alu_res)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			written_q <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
			if (commit) begin
				written_q[rd_s1] <= 1'b1;
			end
		end
	end

	// stage 1 payload: capture instruction and decide the bypass for a same-edge write
	always_ff @(posedge clk) begin
		if (accept) begin
			ins_s1     <= s_axis_tdata;
			fwd_a_s1   <= commit && (rd_s1 == rs1_in);
			fwd_b_s1   <= commit && (rd_s1 == rs2_in);
			zero_a_s1  <= !written_q[rs1_in];
			zero_b_s1  <= !written_q[rs2_in];
			fwd_val_s1 <= alu_res.value;
		end
	end

	// stage 2 payload: hold the result until the beat is taken
	always_ff @(posedge clk) begin
		if (advance) begin
			dest_index_s2 <= rd_s1;
			dest_value_s2 <= alu_res.value;
			write_done_s2 <= !alu_res.illegal && (rd_s1 != '0);
			illegal_s2    <= alu_res.illegal;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {3'b000, dest_value_s2, dest_index_s2};
	assign m_axis_tuser  = {illegal_s2, write_done_s2};

endmodule

### test/rv64i_integer_alu_execute_unit_checker.sv
`timescale 1ns / 100ps
// Checker for the RV64I integer ALU execute unit: watches both streams, predicts each
// write-back from its own copy of the register file and compares result beats in order.
// Depends on rvalu_pkg for the opcode, funct3 and funct7 encodings.
module rv64i_integer_alu_execute_unit_checker
	import rvalu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [71:0] m_tdata,
	input  logic [1:0]  m_tuser,
	output int          failures,
	output int          outstanding
);

	localparam int SHOWN_MAX = 10;

	typedef struct packed {
		logic [4:0]  dest_index;
		logic [63:0] dest_value;
		logic        write_done;
		logic        illegal;
	} writeback_t;

	logic [63:0] arch_regs [REG_COUNT];
	writeback_t  writeback_q [$];
	int          fail_tally;

	function automatic logic [63:0] widen32(input logic [31:0] w);
		return {{32{w[31]}}, w};
	endfunction

	// Work out what one instruction word should retire, given the current register copy.
	function automatic writeback_t execute_alu(input logic [31:0] ins);
		writeback_t  wb;
		logic [6:0]  opc;
		logic [2:0]  f3;
		logic [6:0]  f7;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] imm;
		logic [63:0] val;
		logic        ok;
		opc = ins[6:0];
		f3  = ins[14:12];
		f7  = ins[31:25];
		a   = arch_regs[ins[19:15]];
		b   = arch_regs[ins[24:20]];
		imm = {{52{ins[31]}}, ins[31:20]};
		val = '0;
		ok  = 1'b1;
		case (opc)
			OPC_IMM: begin
				case (f3)
					F3_ADD:  val = a + imm;
					F3_SLT:  val = {63'd0, $signed(a) < $signed(imm)};
					F3_SLTU: val = {63'd0, a < imm};
					F3_XOR:  val = a ^ imm;
					F3_OR:   val = a | imm;
					F3_AND:  val = a & imm;
					F3_SLL: begin
						if (ins[31:26] == TOP6_SRL) val = a << ins[25:20];
						else ok = 1'b0;
					end
					default: begin
						if (ins[31:26] == TOP6_SRL) val = a >> ins[25:20];
						else if (ins[31:26] == TOP6_SRA) val = $signed(a) >>> ins[25:20];
						else ok = 1'b0;
					end
				endcase
			end
			OPC_IMM32: begin
				case (f3)
					F3_ADD: val = widen32(32'(a + imm));
					F3_SLL: begin
						if (f7 == F7_BASE) val = widen32(a[31:0] << ins[24:20]);
						else ok = 1'b0;
					end
					F3_SR: begin
						if (f7 == F7_BASE) val = widen32(a[31:0] >> ins[24:20]);
						else if (f7 == F7_ALT) val = widen32($signed(a[31:0]) >>> ins[24:20]);
						else ok = 1'b0;
					end
					default: ok = 1'b0;
				endcase
			end
			OPC_REG: begin
				if (f7 == F7_ALT) begin
					if (f3 == F3_ADD) val = a - b;
					else if (f3 == F3_SR) val = $signed(a) >>> b[5:0];
					else ok = 1'b0;
				end else if (f7 == F7_BASE) begin
					case (f3)
						F3_ADD:  val = a + b;
						F3_SLL:  val = a << b[5:0];
						F3_SLT:  val = {63'd0, $signed(a) < $signed(b)};
						F3_SLTU: val = {63'd0, a < b};
						F3_XOR:  val = a ^ b;
						F3_SR:   val = a >> b[5:0];
						F3_OR:   val = a | b;
						default: val = a & b;
					endcase
				end else begin
					ok = 1'b0;
				end
			end
			OPC_REG32: begin
				if (f7 == F7_ALT) begin
					if (f3 == F3_ADD) val = widen32(32'(a - b));
					else if (f3 == F3_SR) val = widen32($signed(a[31:0]) >>> b[4:0]);
					else ok = 1'b0;
				end else if (f7 == F7_BASE) begin
					if (f3 == F3_ADD) val = widen32(32'(a + b));
					else if (f3 == F3_SLL) val = widen32(a[31:0] << b[4:0]);
					else if (f3 == F3_SR) val = widen32(a[31:0] >> b[4:0]);
					else ok = 1'b0;
				end else begin
					ok = 1'b0;
				end
			end
			default: ok = 1'b0;
		endcase
		wb.dest_index = ins[11:7];
		wb.dest_value = ok ? val : '0;
		wb.write_done = ok && (ins[11:7] != 5'd0);
		wb.illegal    = !ok;
		return wb;
	endfunction

	always @(posedge clk) begin
		writeback_t want;
		writeback_t got;
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) arch_regs[i] = '0;
			writeback_q.delete();
			fail_tally = 0;
			failures <= 0;
			outstanding <= 0;
		end else begin
			// check the result beat before queueing a new instruction
			if (m_tvalid && m_tready) begin
				got.dest_index = m_tdata[4:0];
				got.dest_value = m_tdata[68:5];
				got.write_done = m_tuser[0];
				got.illegal    = m_tuser[1];
				if (writeback_q.size() == 0) begin
					if (fail_tally < SHOWN_MAX)
						$display("%0t: unexpected result rd=%0d value=%h wr=%b ill=%b",
							$realtime, got.dest_index, got.dest_value, got.write_done,
							got.illegal);
					fail_tally++;
				end else begin
					want = writeback_q.pop_front();
					if (got !== want) begin
						if (fail_tally < SHOWN_MAX)
							$display("%0t: exp %0d %h %b %b got %0d %h %b %b",
								$realtime,
								want.dest_index, want.dest_value, want.write_done,
								want.illegal, got.dest_index, got.dest_value,
								got.write_done, got.illegal);
						fail_tally++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				want = execute_alu(s_tdata);
				writeback_q.push_back(want);
				if (want.write_done) arch_regs[want.dest_index] = want.dest_value;
			end
			failures <= fail_tally;
			outstanding <= writeback_q.size();
		end
	end

endmodule

### test/rv64i_integer_alu_execute_unit_tb.sv
`timescale 1ns / 100ps
// Top-level testbench for the RV64I integer ALU execute unit: drives instruction beats,
// drives result back-pressure and prints the verdict.
// Depends on rvalu_pkg, the unit under test and rv64i_integer_alu_execute_unit_checker.
module rv64i_integer_alu_execute_unit_tb
	import rvalu_pkg::*;
();

	localparam int         HOLD_CYCLES = 300;      // length of the receiver hold-off
	localparam int         DRAIN_WAIT  = 10;       // margin past the pipeline latency
	localparam realtime    LIMIT_NS    = 5_000_000;
	localparam logic [6:0] OPC_LOAD    = 7'h03;    // not executed here
	localparam logic [6:0] F7_MULDIV   = 7'h01;    // M extension, not supported

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;    // [31:0] instruction
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [71:0] m_axis_tdata;    // [4:0] dest_index, [68:5] dest_value, [71:69] zero
	logic [1:0]  m_axis_tuser;    // [0] write_done, [1] illegal

	int failures;
	int outstanding;

	// Stimulus-side controls read by the receiver process.
	bit steady;        // no idling on either side while set, a requested receiver hold-off apart
	int hold_asks;     // bumped once per requested receiver hold-off

	always #5 clk = ~clk;

	rv64i_integer_alu_execute_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	rv64i_integer_alu_execute_unit_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_axis_tvalid),
		.s_tready   (s_axis_tready),
		.s_tdata    (s_axis_tdata),
		.m_tvalid   (m_axis_tvalid),
		.m_tready   (m_axis_tready),
		.m_tdata    (m_axis_tdata),
		.m_tuser    (m_axis_tuser),
		.failures   (failures),
		.outstanding(outstanding)
	);

	// R-type and I-type encoders
	function automatic logic [31:0] r_word(input logic [6:0] f7, input logic [4:0] rs2,
		input logic [4:0] rs1, input logic [2:0] f3, input logic [4:0] rd,
		input logic [6:0] opc);
		return {f7, rs2, rs1, f3, rd, opc};
	endfunction

	function automatic logic [31:0] i_word(input logic [11:0] imm, input logic [4:0] rs1,
		input logic [2:0] f3, input logic [4:0] rd, input logic [6:0] opc);
		return {imm, rs1, f3, rd, opc};
	endfunction

	// Mostly well-formed ALU instructions with random operands; a share of raw noise
	// and of near-miss encodings to exercise the illegal path.
	function automatic logic [31:0] random_alu_word();
		logic [6:0]  opc;
		logic [2:0]  f3;
		logic [6:0]  f7;
		logic [4:0]  rd;
		logic [4:0]  rs1;
		logic [4:0]  rs2;
		logic [11:0] imm;
		int          pick;
		pick = $urandom_range(0, 99);
		if (pick < 8) return $urandom();
		rd  = 5'($urandom_range(0, 31));
		rs1 = 5'($urandom_range(0, 31));
		rs2 = 5'($urandom_range(0, 31));
		f3  = 3'($urandom_range(0, 7));
		imm = 12'($urandom_range(0, 4095));
		// funct7: mostly base, sometimes alternate, rarely anything
		pick = $urandom_range(0, 99);
		f7 = (pick < 60) ? F7_BASE : (pick < 92) ? F7_ALT : 7'($urandom_range(0, 127));
		case ($urandom_range(0, 3))
			0: begin
				opc = OPC_IMM;
				if (f3 == F3_SLL)
					imm[11:6] = ($urandom_range(0, 9) == 0) ? 6'($urandom()) : TOP6_SRL;
				else if (f3 == F3_SR)
					imm[11:6] = ($urandom_range(0, 9) == 0) ? 6'($urandom()) :
						($urandom_range(0, 1) ? TOP6_SRA : TOP6_SRL);
				return i_word(imm, rs1, f3, rd, opc);
			end
			1: begin
				opc = OPC_IMM32;
				// bias funct3 towards the three encodings that exist
				if ($urandom_range(0, 9) != 0) begin
					pick = $urandom_range(0, 2);
					f3 = (pick == 0) ? F3_ADD : (pick == 1) ? F3_SLL : F3_SR;
				end
				if (f3 != F3_ADD) imm[11:5] = f7;
				return i_word(imm, rs1, f3, rd, opc);
			end
			2: return r_word(f7, rs2, rs1, f3, rd, OPC_REG);
			default: return r_word(f7, rs2, rs1, f3, rd, OPC_REG32);
		endcase
	endfunction

	// Offer one beat and hold it until accepted; valid stays high for the next call.
	task automatic offer(input logic [31:0] word);
		if (!steady && $urandom_range(0, 99) < 7) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= word;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Drop valid and wait until every predicted write-back has been seen.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Receiver: random back-pressure, a steady stretch, and a counted hold-off on request.
	initial begin : receiver
		int hold_served;
		int hold_count;
		hold_served = 0;
		hold_count  = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_served != hold_asks) begin
				m_axis_tready <= 1'b0;
				hold_count++;
				if (hold_count == HOLD_CYCLES) begin
					hold_count = 0;
					hold_served++;
				end
			end else begin
				m_axis_tready <= steady || ($urandom_range(0, 99) >= 15);
			end
		end
	end

	initial begin : stimulus
		logic [31:0] prelude [$];
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		steady        = 1'b0;
		hold_asks     = 0;
		prelude = '{
			// seed registers with extremes: all ones, max immediate, sign bit, max positive
			i_word(12'hfff, 5'd0, F3_ADD, 5'd1, OPC_IMM),
			i_word(12'h7ff, 5'd0, F3_ADD, 5'd2, OPC_IMM),
			i_word({TOP6_SRL, 6'd63}, 5'd1, F3_SLL, 5'd3, OPC_IMM),
			i_word({TOP6_SRL, 6'd1}, 5'd1, F3_SR, 5'd4, OPC_IMM),
			i_word({TOP6_SRA, 6'd63}, 5'd3, F3_SR, 5'd5, OPC_IMM),
			// add into x0: value shows, nothing is written
			r_word(F7_BASE, 5'd2, 5'd1, F3_ADD, 5'd0, OPC_REG),
			r_word(F7_ALT, 5'd3, 5'd0, F3_ADD, 5'd6, OPC_REG),
			r_word(F7_BASE, 5'd4, 5'd3, F3_SLT, 5'd7, OPC_REG),
			r_word(F7_BASE, 5'd4, 5'd3, F3_SLTU, 5'd8, OPC_REG),
			i_word(12'h800, 5'd3, F3_SLT, 5'd9, OPC_IMM),
			i_word(12'hfff, 5'd2, F3_SLTU, 5'd10, OPC_IMM),
			r_word(F7_BASE, 5'd2, 5'd4, F3_XOR, 5'd11, OPC_REG),
			r_word(F7_BASE, 5'd2, 5'd3, F3_OR, 5'd12, OPC_REG),
			r_word(F7_BASE, 5'd1, 5'd4, F3_AND, 5'd13, OPC_REG),
			i_word(12'h800, 5'd4, F3_XOR, 5'd14, OPC_IMM),
			i_word(12'h555, 5'd3, F3_OR, 5'd15, OPC_IMM),
			i_word(12'hfff, 5'd4, F3_AND, 5'd16, OPC_IMM),
			// register shifts by 63 (amount from the low six bits of all ones)
			r_word(F7_BASE, 5'd1, 5'd2, F3_SLL, 5'd17, OPC_REG),
			r_word(F7_BASE, 5'd1, 5'd3, F3_SR, 5'd18, OPC_REG),
			r_word(F7_ALT, 5'd1, 5'd3, F3_SR, 5'd19, OPC_REG),
			// word forms, results sign-extended from bit 31
			i_word(12'h7ff, 5'd4, F3_ADD, 5'd20, OPC_IMM32),
			i_word({F7_BASE, 5'd31}, 5'd1, F3_SLL, 5'd21, OPC_IMM32),
			i_word({F7_ALT, 5'd4}, 5'd21, F3_SR, 5'd22, OPC_IMM32),
			i_word({F7_BASE, 5'd31}, 5'd21, F3_SR, 5'd23, OPC_IMM32),
			r_word(F7_ALT, 5'd2, 5'd3, F3_ADD, 5'd24, OPC_REG32),
			r_word(F7_BASE, 5'd1, 5'd21, F3_SLL, 5'd25, OPC_REG32),
			r_word(F7_BASE, 5'd1, 5'd21, F3_SR, 5'd26, OPC_REG32),
			r_word(F7_ALT, 5'd1, 5'd21, F3_SR, 5'd27, OPC_REG32),
			r_word(F7_BASE, 5'd4, 5'd4, F3_ADD, 5'd28, OPC_REG32),
			// unsupported encodings must leave x1 untouched
			i_word(12'h000, 5'd0, F3_ADD, 5'd1, OPC_LOAD),
			i_word({6'h10, 6'd1}, 5'd1, F3_SLL, 5'd1, OPC_IMM),
			i_word({6'h20, 6'd1}, 5'd1, F3_SR, 5'd1, OPC_IMM),
			i_word({F7_MULDIV, 5'd1}, 5'd1, F3_SLL, 5'd1, OPC_IMM32),
			r_word(F7_MULDIV, 5'd2, 5'd1, F3_ADD, 5'd1, OPC_REG),
			r_word(F7_BASE, 5'd2, 5'd1, F3_SLT, 5'd1, OPC_REG32),
			32'hffff_ffff
		};

		// Hold reset, release it on an edge and never assert it again.
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (prelude[i]) offer(prelude[i]);

		repeat (250) offer(random_alu_word());

		// Hold the receiver off while beats keep coming, so the unit backs up
		// and drops tready.
		steady = 1'b1;
		hold_asks++;
		repeat (100) offer(random_alu_word());

		// Pause the sender until the unit has emptied.
		drain();

		// Full-rate stretch: no idling on either side.
		repeat (200) offer(random_alu_word());

		steady = 1'b0;
		repeat (220) offer(random_alu_word());

		drain();
		repeat (DRAIN_WAIT) @(posedge clk);

		if (failures == 0)
			$display("** rv64i_integer_alu_execute_unit: PASSED **");
		else
			$display("** rv64i_integer_alu_execute_unit: FAILED **");
		$finish;
	end

	initial begin : watchdog
		#(LIMIT_NS);
		$display("** rv64i_integer_alu_execute_unit: FAILED **");
		$finish;
	end

endmodule
